/* rtl/vfc_pkg.sv */
`default_nettype none
package vfc_pkg;

  // Field widths
  localparam int VERTEX_W = 6;
  localparam int COORD_W  = 32;
  localparam int GAIN_W   = 31;
  localparam int STEP_W   = 17;
  localparam int ACTV_W   = 7;

  // Internal datapath widths
  localparam int FORCE_W  = 50;   // summed force component
  localparam int MA_W     = 34;   // multiplier operand a
  localparam int MB_W     = 33;   // multiplier operand b
  localparam int PROD_W   = 67;   // product

  // Defaults and fixed saturation width of the velocity result
  localparam int MAX_VERTICES_DEF = 64;
  localparam int VALUE_WIDTH      = 32;

  localparam logic [STEP_W-1:0] STEP_TIME_RST = 17'd655;
  localparam logic [ACTV_W-1:0] ACTIVE_RST    = 7'd64;

  // Configuration register indexes
  localparam logic CFG_STEP_TIME = 1'b0;
  localparam logic CFG_ACTIVE    = 1'b1;

  // Mode flag bit positions
  localparam int FLAG_POS = 0;
  localparam int FLAG_VEL = 1;
  localparam int FLAG_FRC = 2;

  // Request op codes
  typedef enum logic [2:0] {
    OP_SET_POS = 3'd0,
    OP_SET_VEL = 3'd1,
    OP_SET_FRC = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_APPLY   = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [VERTEX_W-1:0] vertex;
    logic signed [31:0]  a_x;
    logic signed [31:0]  a_y;
    logic signed [31:0]  a_z;
    logic signed [31:0]  b_x;
    logic signed [31:0]  b_y;
    logic signed [31:0]  b_z;
    logic [GAIN_W-1:0]   gain;
    logic [GAIN_W-1:0]   limit;
  } req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               controlled;
    logic               clamped;
  } rsp_t;

  // One control table entry
  typedef struct packed {
    logic [2:0][31:0]  tpos;
    logic [2:0][31:0]  tvel;
    logic [2:0][31:0]  frc;
    logic [GAIN_W-1:0] pgain;
    logic [GAIN_W-1:0] vgain;
    logic [GAIN_W-1:0] lim;
    logic [2:0]        flags;
  } entry_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    DC_NOP       = 5'd0,
    DC_LOAD      = 5'd1,
    DC_WRITE     = 5'd2,
    DC_REMOVE    = 5'd3,
    DC_CLEAR     = 5'd4,
    DC_ECHO      = 5'd5,
    DC_TERM_MUL  = 5'd6,
    DC_TERM_ACC  = 5'd7,
    DC_FRC_ADD   = 5'd8,
    DC_MAG       = 5'd9,
    DC_SHIFT     = 5'd10,
    DC_SQ_MUL    = 5'd11,
    DC_SQ_ACC    = 5'd12,
    DC_LSQ_MUL   = 5'd13,
    DC_CMP       = 5'd14,
    DC_SQRT      = 5'd15,
    DC_DIV_MUL   = 5'd16,
    DC_DIV_INIT  = 5'd17,
    DC_DIV_STEP  = 5'd18,
    DC_DIV_STORE = 5'd19,
    DC_DT_LO     = 5'd20,
    DC_DT_HI     = 5'd21,
    DC_DT_OUT    = 5'd22
  } dp_code_t;

  typedef struct packed {
    dp_code_t   code;
    logic [1:0] k;      // component
    logic       t;      // term: 0 position, 1 velocity
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_range;
    logic       controlled;
    logic       big;
    logic       over;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/vfc_dp.sv */
`default_nettype none
module vfc_dp import vfc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire req_t              in_req,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [STEP_W-1:0] cfg_data,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output rsp_t                   out_rsp
);

  // Only the first 64 entries are reachable through the vertex field
  localparam int DEPTH = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [53:0] SAT_HI = (54'sd1 <<< (VALUE_WIDTH - 1)) - 54'sd1;
  localparam logic signed [53:0] SAT_LO = -SAT_HI - 54'sd1;

  function automatic logic [31:0] sat_out(input logic signed [53:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = SAT_HI[31:0];
    else if (v < SAT_LO) r = SAT_LO[31:0];
    else r = v[31:0];
    return r;
  endfunction

  logic [STEP_W-1:0]        step_r;
  logic [ACTV_W-1:0]        active_r;
  req_t                     req_r;
  entry_t                   mem_r [DEPTH];
  logic [DEPTH-1:0]         valid_r;
  entry_t                   rd_r;
  logic                     rd_valid_r;
  logic signed [FORCE_W-1:0] f_r   [3];
  logic [FORCE_W-1:0]       mag_r [3];
  logic [63:0]              ss_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [PROD_W-1:0] acc_r;
  logic [63:0]              x_r, r_r, bit_r;
  logic [31:0]              rem_r;
  logic [30:0]              dq_r;
  logic                     clamped_r, over_r;
  rsp_t                     res_r;

  logic [AW-1:0]            addr;
  entry_t                   ent, merged;
  logic signed [31:0]       a_v [3];
  logic signed [31:0]       b_v [3];
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [FORCE_W-1:0] fk;
  logic [FORCE_W-1:0]       mag_f [3];
  logic                     big_f;
  logic [64:0]              rb;
  logic [32:0]              dv_t;
  logic                     dv_ge;
  logic [FORCE_W-1:0]       q_ext;
  logic signed [67:0]       dsum, dshift;
  logic signed [53:0]       dval;
  logic [31:0]              vel_new;

  assign addr = req_r.vertex[AW-1:0];
  assign ent  = rd_valid_r ? rd_r : '0;
  assign a_v[0] = req_r.a_x;
  assign a_v[1] = req_r.a_y;
  assign a_v[2] = req_r.a_z;
  assign b_v[0] = req_r.b_x;
  assign b_v[1] = req_r.b_y;
  assign b_v[2] = req_r.b_z;
  assign fk = f_r[cmd.k];

  // Merge of a set request into the stored entry
  always_comb begin
    merged = ent;
    case (req_r.op)
      OP_SET_POS: begin
        merged.tpos = {req_r.a_z, req_r.a_y, req_r.a_x};
        merged.flags[FLAG_POS] = 1'b1;
        merged.pgain = req_r.gain;
        merged.lim = req_r.limit;
      end
      OP_SET_VEL: begin
        merged.tvel = {req_r.a_z, req_r.a_y, req_r.a_x};
        merged.flags[FLAG_VEL] = 1'b1;
        merged.vgain = req_r.gain;
        merged.lim = req_r.limit;
      end
      OP_SET_FRC: begin
        merged.frc = {req_r.a_z, req_r.a_y, req_r.a_x};
        merged.flags[FLAG_FRC] = 1'b1;
      end
      default: merged = ent;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.code)
      DC_TERM_MUL: begin
        if (!cmd.t) begin
          ma = MA_W'($signed(ent.tpos[cmd.k])) - MA_W'(a_v[cmd.k]);
          mb = ent.flags[FLAG_POS] ? MB_W'({2'b0, ent.pgain}) : '0;
        end else begin
          ma = MA_W'($signed(ent.tvel[cmd.k])) - MA_W'(b_v[cmd.k]);
          mb = ent.flags[FLAG_VEL] ? MB_W'({2'b0, ent.vgain}) : '0;
        end
      end
      DC_SQ_MUL: begin
        ma = MA_W'({3'b0, mag_r[cmd.k][30:0]});
        mb = MB_W'({2'b0, mag_r[cmd.k][30:0]});
      end
      DC_LSQ_MUL: begin
        ma = MA_W'({3'b0, ent.lim});
        mb = MB_W'({2'b0, ent.lim});
      end
      DC_DIV_MUL: begin
        ma = MA_W'({3'b0, mag_r[cmd.k][30:0]});
        mb = MB_W'({2'b0, ent.lim});
      end
      DC_DT_LO: begin
        ma = MA_W'({9'b0, fk[24:0]});
        mb = MB_W'({16'b0, step_r});
      end
      DC_DT_HI: begin
        ma = MA_W'({{9{fk[FORCE_W-1]}}, fk[FORCE_W-1:25]});
        mb = MB_W'({16'b0, step_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // Magnitudes of the summed force
  always_comb begin
    big_f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_f[i] = f_r[i][FORCE_W-1] ? FORCE_W'(-f_r[i]) : FORCE_W'(f_r[i]);
      big_f = big_f | (|mag_f[i][FORCE_W-1:31]);
    end
  end

  // Square root and divider step logic
  assign rb    = {1'b0, r_r} + {1'b0, bit_r};
  assign dv_t  = {rem_r, dq_r[30]};
  assign dv_ge = (dv_t >= {1'b0, r_r[31:0]});
  assign q_ext = FORCE_W'(dq_r);

  // Velocity update: b + floor(f * dt / 2^16)
  assign dsum    = 68'(acc_r) + (68'(p_r) <<< 25);
  assign dshift  = dsum >>> 16;
  assign dval    = dshift[53:0] + 54'(b_v[cmd.k]);
  assign vel_new = sat_out(dval);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_TIME_RST;
      active_r <= ACTIVE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_TIME: step_r   <= cfg_data;
        CFG_ACTIVE:    active_r <= cfg_data[ACTV_W-1:0];
        default:       step_r   <= step_r;
      endcase
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      case (cmd.code)
        DC_WRITE:  valid_r[addr] <= 1'b1;
        DC_REMOVE: valid_r[addr] <= 1'b0;
        DC_CLEAR:  valid_r <= '0;
        default:   valid_r <= valid_r;
      endcase
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.code == DC_WRITE) mem_r[addr] <= merged;
    if (cmd.code == DC_LOAD) begin
      rd_r       <= mem_r[in_req.vertex[AW-1:0]];
      rd_valid_r <= valid_r[in_req.vertex[AW-1:0]];
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      DC_LOAD: begin
        req_r <= in_req;
        res_r <= '0;
        for (int i = 0; i < 3; i++) f_r[i] <= '0;
      end
      DC_ECHO: begin
        res_r.vel_x <= sat_out(54'(req_r.b_x));
        res_r.vel_y <= sat_out(54'(req_r.b_y));
        res_r.vel_z <= sat_out(54'(req_r.b_z));
      end
      DC_TERM_MUL, DC_SQ_MUL, DC_LSQ_MUL, DC_DIV_MUL, DC_DT_LO: p_r <= prod;
      DC_TERM_ACC: f_r[cmd.k] <= fk + $signed(p_r[65:16]);
      DC_FRC_ADD: begin
        if (ent.flags[FLAG_FRC]) f_r[cmd.k] <= fk + FORCE_W'($signed(ent.frc[cmd.k]));
      end
      DC_MAG: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_f[i];
        clamped_r <= big_f;
        ss_r <= '0;
      end
      DC_SHIFT: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end
      DC_SQ_ACC: ss_r <= ss_r + p_r[63:0];
      DC_CMP: begin
        over_r <= clamped_r | (ss_r > p_r[63:0]);
        x_r    <= ss_r;
        r_r    <= '0;
        bit_r  <= 64'd1 << 62;
      end
      DC_SQRT: begin
        if ({1'b0, x_r} >= rb) begin
          x_r <= x_r - rb[63:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      DC_DIV_INIT: begin
        rem_r <= {1'b0, p_r[61:31]};
        dq_r  <= p_r[30:0];
      end
      DC_DIV_STEP: begin
        rem_r <= dv_ge ? 32'(dv_t - {1'b0, r_r[31:0]}) : dv_t[31:0];
        dq_r  <= {dq_r[29:0], dv_ge};
      end
      DC_DIV_STORE: begin
        if (r_r[31:0] == 32'd0) f_r[cmd.k] <= '0;
        else f_r[cmd.k] <= fk[FORCE_W-1] ? -$signed(q_ext) : $signed(q_ext);
      end
      DC_DT_HI: begin
        acc_r <= p_r;
        p_r   <= prod;
      end
      DC_DT_OUT: begin
        case (cmd.k)
          2'd0:    res_r.vel_x <= vel_new;
          2'd1:    res_r.vel_y <= vel_new;
          default: res_r.vel_z <= vel_new;
        endcase
        res_r.controlled <= 1'b1;
        res_r.clamped    <= over_r;
      end
      default: res_r <= res_r;
    endcase
  end

  // Status to the controller
  always_comb begin
    stat.op         = req_r.op;
    stat.in_range   = ({26'b0, req_r.vertex} < 32'(MAX_VERTICES));
    stat.controlled = stat.in_range && ({1'b0, req_r.vertex} < active_r) && rd_valid_r;
    stat.big        = (|mag_r[0][FORCE_W-1:31]) | (|mag_r[1][FORCE_W-1:31])
                    | (|mag_r[2][FORCE_W-1:31]);
    stat.over       = over_r;
  end

  assign out_rsp = res_r;

endmodule
`default_nettype wire

/* rtl/vfc_ctrl.sv */
`default_nettype none
module vfc_ctrl import vfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_DECODE    = 21'h000002,
    S_TERM_MUL  = 21'h000004,
    S_TERM_ACC  = 21'h000008,
    S_FRC       = 21'h000010,
    S_MAG       = 21'h000020,
    S_SHIFT     = 21'h000040,
    S_SQ_MUL    = 21'h000080,
    S_SQ_ACC    = 21'h000100,
    S_LSQ       = 21'h000200,
    S_CMP       = 21'h000400,
    S_CHECK     = 21'h000800,
    S_SQRT      = 21'h001000,
    S_DIV_MUL   = 21'h002000,
    S_DIV_INIT  = 21'h004000,
    S_DIV       = 21'h008000,
    S_DIV_STORE = 21'h010000,
    S_DT_LO     = 21'h020000,
    S_DT_HI     = 21'h040000,
    S_DT_OUT    = 21'h080000,
    S_DONE      = 21'h100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       t_r, t_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      t_r     <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    cnt_nxt   = cnt_r;
    cmd.code  = DC_NOP;
    cmd.k     = k_r;
    cmd.t     = t_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.code  = DC_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        k_nxt     = '0;
        t_nxt     = 1'b0;
        case (stat.op)
          OP_SET_POS, OP_SET_VEL, OP_SET_FRC: begin
            if (stat.in_range) cmd.code = DC_WRITE;
          end
          OP_REMOVE: begin
            if (stat.in_range) cmd.code = DC_REMOVE;
          end
          OP_CLEAR: cmd.code = DC_CLEAR;
          OP_APPLY: begin
            if (stat.controlled) state_nxt = S_TERM_MUL;
            else cmd.code = DC_ECHO;
          end
          default: cmd.code = DC_NOP;
        endcase
      end
      // gain terms and external force, one component at a time
      S_TERM_MUL: begin
        cmd.code  = DC_TERM_MUL;
        state_nxt = S_TERM_ACC;
      end
      S_TERM_ACC: begin
        cmd.code = DC_TERM_ACC;
        if (!t_r) begin
          t_nxt     = 1'b1;
          state_nxt = S_TERM_MUL;
        end else begin
          state_nxt = S_FRC;
        end
      end
      S_FRC: begin
        cmd.code = DC_FRC_ADD;
        t_nxt    = 1'b0;
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_MAG;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_TERM_MUL;
        end
      end
      S_MAG: begin
        cmd.code  = DC_MAG;
        state_nxt = S_SHIFT;
      end
      // bring all magnitudes below 2^31
      S_SHIFT: begin
        if (stat.big) cmd.code = DC_SHIFT;
        else state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.code  = DC_SQ_MUL;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.code = DC_SQ_ACC;
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_LSQ;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_LSQ: begin
        cmd.code  = DC_LSQ_MUL;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.code  = DC_CMP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        k_nxt   = '0;
        if (stat.over) state_nxt = S_SQRT;
        else state_nxt = S_DT_LO;
      end
      // 32 digit steps of the integer square root
      S_SQRT: begin
        cmd.code = DC_SQRT;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        cmd.code  = DC_DIV_MUL;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.code  = DC_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      // 31 quotient bits, one per cycle
      S_DIV: begin
        cmd.code = DC_DIV_STEP;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd30) state_nxt = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd.code = DC_DIV_STORE;
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_DT_LO;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DIV_MUL;
        end
      end
      S_DT_LO: begin
        cmd.code  = DC_DT_LO;
        state_nxt = S_DT_HI;
      end
      S_DT_HI: begin
        cmd.code  = DC_DT_HI;
        state_nxt = S_DT_OUT;
      end
      S_DT_OUT: begin
        cmd.code = DC_DT_OUT;
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DT_LO;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule
`default_nettype wire

/* rtl/vertex_force_controller_core.sv */
// Table requests and uncontrolled apply requests are loaded, decoded and then strobed;
// a controlled apply runs through the force, limit and velocity steps, and more when
// the force is clamped (shift, 32-step square root, three 31-step divisions).
// Requests are handled one at a time; a new request is taken the cycle after the strobe.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous active-low reset empties the table and restores step_time and vertex count.
`default_nettype none
module vertex_force_controller_core import vfc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              in_req,
  output logic                   out_valid,
  output rsp_t                   out_rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [STEP_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration is written only while idle
  assign cfg_ready = !busy;

  vfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  vfc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire
